### rtl/core/max_tracking_fifo_macros.svh
// ============================================================================
// max_tracking_fifo_macros.svh
// Assertion macros for the max tracking queue. The checks compile away when
// SYNTHESIS is defined.
// ============================================================================
`ifndef MAX_TRACKING_FIFO_MACROS_SVH
`define MAX_TRACKING_FIFO_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define MTF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// A condition at one edge that implies another at the next edge.
`define MTF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`else

`define MTF_ASSERT_ALWAYS(label, prop, msg)
`define MTF_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/core/mtf_pkg.sv
// ============================================================================
// mtf_pkg
// Shared codes and types of the max tracking queue.
// ============================================================================
`default_nettype none

package mtf_pkg;

    // Operation codes of an input item. Any other code acts as a read.
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Status codes of a result item.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } mtf_cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/mtf_cell.sv
// ============================================================================
// mtf_cell
// One slot of the shifting queue: holds a value, its suffix maximum and an
// occupancy bit, and takes its neighbor's contents when the oldest item leaves.
// ============================================================================
`default_nettype none

module mtf_cell
    import mtf_pkg::*;
#(
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mtf_cell_ctrl_t        ctrl,
    input  wire logic [DATA_WIDTH-1:0] push_value,
    input  wire logic                  prev_valid,
    input  wire logic                  next_valid,
    input  wire logic [DATA_WIDTH-1:0] next_value,
    input  wire logic [DATA_WIDTH-1:0] next_smax,
    output logic                       valid,
    output logic [DATA_WIDTH-1:0]      value,
    output logic [DATA_WIDTH-1:0]      smax
);

    logic                  valid_reg, valid_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic [DATA_WIDTH-1:0] smax_reg,  smax_next;

    // A pop shifts the chain toward the front. A push raises an occupied
    // cell's suffix maximum, or fills the first free cell.
    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        smax_next  = smax_reg;
        if (ctrl.pop) begin
            valid_next = next_valid;
            value_next = next_value;
            smax_next  = next_smax;
        end else if (ctrl.push) begin
            if (valid_reg) begin
                if (smax_reg < push_value) begin
                    smax_next = push_value;
                end
            end else if (prev_valid) begin
                valid_next = 1'b1;
                value_next = push_value;
                smax_next  = push_value;
            end
        end
    end

    // Only the occupancy bit is reset; the payload is qualified by it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
        smax_reg  <= smax_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;
    assign smax  = smax_reg;

endmodule

`default_nettype wire

### rtl/core/max_tracking_fifo.sv
// ============================================================================
// max_tracking_fifo
// First-in first-out queue of up to DEPTH values that reports its front,
// back and maximum after every operation.
// ============================================================================
//
//   Channel   Ports                          Direction   Carries
//   --------  -----------------------------  ----------  ----------------------
//   input     s_valid s_ready s_cmd s_value  in          one operation
//   result    m_valid m_ready m_front_value  out         queue state after it
//             m_back_value m_max_value
//             m_count m_is_empty m_status
//
// Each accepted item updates all suffix maxima of the cell chain in parallel,
// and its result is loaded into the output register at the same clock edge.
// A new item is accepted whenever the output register is empty or being taken,
// so the block sustains one item per cycle.
// A synchronous reset clears the occupancy bits, the count and the output
// valid bit; no clearing pass follows.
// A stalled result only holds off the next item; nothing is lost.
// ============================================================================
`default_nettype none

`include "max_tracking_fifo_macros.svh"

module max_tracking_fifo
    import mtf_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [1:0]                   s_cmd,
    input  wire logic [DATA_WIDTH-1:0]        s_value,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [DATA_WIDTH-1:0]             m_front_value,
    output logic [DATA_WIDTH-1:0]             m_back_value,
    output logic [DATA_WIDTH-1:0]             m_max_value,
    output logic [$clog2(DEPTH+1)-1:0]        m_count,
    output logic                              m_is_empty,
    output logic [1:0]                        m_status
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_COUNT  = CW'(1);

    // Queue bookkeeping.
    logic [CW-1:0]         count_reg, count_next;
    logic [DATA_WIDTH-1:0] back_reg, back_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_front_reg, out_back_reg, out_max_reg;
    logic [CW-1:0]         out_count_reg;
    logic                  out_empty_reg;
    logic [1:0]            out_status_reg;

    // Cell chain wiring.
    logic [DEPTH-1:0]      cell_valid;
    logic [DATA_WIDTH-1:0] cell_value [DEPTH];
    logic [DATA_WIDTH-1:0] cell_smax  [DEPTH];
    mtf_cell_ctrl_t        cell_ctrl;

    // Decode of the current item.
    logic                  accept;
    logic                  is_push, is_pop, full, empty;
    logic                  refused_push;
    logic [DATA_WIDTH-1:0] res_front, res_back, res_max;
    logic [1:0]            res_status;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_push = (s_cmd == CMD_PUSH);
    assign is_pop  = (s_cmd == CMD_POP);
    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);

    assign refused_push = accept && is_push && full;

    assign cell_ctrl.push = accept && is_push && !full;
    assign cell_ctrl.pop  = accept && is_pop && !empty;

    // The chain of cells, front at index zero.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                  prev_v;
        logic                  nxt_v;
        logic [DATA_WIDTH-1:0] nxt_value, nxt_smax;

        if (i == 0) begin : g_first
            assign prev_v = 1'b1;
        end else begin : g_inner
            assign prev_v = cell_valid[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign nxt_v     = 1'b0;
            assign nxt_value = '0;
            assign nxt_smax  = '0;
        end else begin : g_link
            assign nxt_v     = cell_valid[i+1];
            assign nxt_value = cell_value[i+1];
            assign nxt_smax  = cell_smax[i+1];
        end

        mtf_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl),
            .push_value (s_value),
            .prev_valid (prev_v),
            .next_valid (nxt_v),
            .next_value (nxt_value),
            .next_smax  (nxt_smax),
            .valid      (cell_valid[i]),
            .value      (cell_value[i]),
            .smax       (cell_smax[i])
        );
    end

    // Count and newest value after the item.
    always_comb begin
        count_next = count_reg;
        back_next  = back_reg;
        if (cell_ctrl.push) begin
            count_next = count_reg + ONE_COUNT;
            back_next  = s_value;
        end else if (cell_ctrl.pop) begin
            count_next = count_reg - ONE_COUNT;
        end
    end

    // Result fields, taken from what the cells will hold after the item.
    always_comb begin
        res_front  = '0;
        res_max    = '0;
        res_status = STATUS_OK;
        if (is_push) begin
            if (full) begin
                res_status = STATUS_FULL;
                res_front  = cell_value[0];
                res_max    = cell_smax[0];
            end else if (empty) begin
                res_front = s_value;
                res_max   = s_value;
            end else begin
                res_front = cell_value[0];
                res_max   = (cell_smax[0] < s_value) ? s_value : cell_smax[0];
            end
        end else if (empty) begin
            res_status = STATUS_EMPTY;
        end else if (is_pop) begin
            if (count_reg != ONE_COUNT) begin
                res_front = cell_value[1];
                res_max   = cell_smax[1];
            end
        end else begin
            res_front = cell_value[0];
            res_max   = cell_smax[0];
        end
        res_back = (count_next == '0) ? '0 : back_next;
    end

    // The output register is loaded on accept and freed when taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        back_reg <= back_next;
        if (accept) begin
            out_front_reg  <= res_front;
            out_back_reg   <= res_back;
            out_max_reg    <= res_max;
            out_count_reg  <= count_next;
            out_empty_reg  <= (count_next == '0);
            out_status_reg <= res_status;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_front_value = out_front_reg;
    assign m_back_value  = out_back_reg;
    assign m_max_value   = out_max_reg;
    assign m_count       = out_count_reg;
    assign m_is_empty    = out_empty_reg;
    assign m_status      = out_status_reg;

    // The occupancy bits of the chain always agree with the count.
    `MTF_ASSERT_ALWAYS(a_occupancy, $countones(cell_valid) == 32'(count_reg), "occupancy mismatch")

    // The count never passes the depth.
    `MTF_ASSERT_ALWAYS(a_count_bounded, count_reg <= FULL_COUNT, "count exceeds the queue depth")

    // A refused push leaves the count unchanged.
    `MTF_ASSERT_NEXT(a_full_hold, refused_push, $stable(count_reg), "refused push moved count")

    // A result never reports a maximum below its front value.
    `MTF_ASSERT_ALWAYS(a_max_front, !m_valid || (m_max_value >= m_front_value), "max below front")

endmodule

`default_nettype wire

### sim/max_queue_checker.sv
// ----------------------------------------------------------------------------
// max_queue_checker
// Watches both channels of the max tracking queue. Every accepted operation
// is applied to a local copy of the queue, and the queue state it leaves
// behind is stored. Every accepted result is compared with the oldest stored
// state, field by field.
// ----------------------------------------------------------------------------
module max_queue_checker
    import mtf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_front_value,
    input  logic [15:0] m_back_value,
    input  logic [15:0] m_max_value,
    input  logic [4:0]  m_count,
    input  logic        m_is_empty,
    input  logic [1:0]  m_status,
    output int          fail_count,
    output int          pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [15:0] front_value;
        logic [15:0] back_value;
        logic [15:0] max_value;
        logic [4:0]  count;
        logic        is_empty;
        logic [1:0]  status;
    } queue_view_t;

    // Local copy of the ring storage and its pointers.
    logic [15:0] slot_value [QUEUE_DEPTH];
    logic [15:0] slot_suffix_max [QUEUE_DEPTH];
    logic [3:0]  head_slot = '0;
    logic [3:0]  tail_slot = '0;
    logic [4:0]  held = '0;

    queue_view_t expected_views[$];
    int          reported = 0;

    // Apply one operation to the local queue and return the view after it.
    function automatic queue_view_t apply_queue_op(input logic [1:0] op,
                                                   input logic [15:0] val);
        queue_view_t view;
        logic [3:0]  slot;
        view = '0;
        view.status = STATUS_OK;
        if (op == CMD_PUSH) begin
            if (held == QUEUE_DEPTH) begin
                view.status = STATUS_FULL;
            end else begin
                // Raise every stored suffix maximum that is below the new value.
                for (int i = 0; i < held; i++) begin
                    slot = head_slot + 4'(i);
                    if (slot_suffix_max[slot] < val)
                        slot_suffix_max[slot] = val;
                end
                slot_value[tail_slot] = val;
                slot_suffix_max[tail_slot] = val;
                tail_slot = tail_slot + 4'd1;
                held = held + 5'd1;
            end
        end else if (op == CMD_POP) begin
            if (held == 0) begin
                view.status = STATUS_EMPTY;
            end else begin
                head_slot = head_slot + 4'd1;
                held = held - 5'd1;
            end
        end else begin
            // A read, and any unused code, leaves the queue alone.
            if (held == 0)
                view.status = STATUS_EMPTY;
        end
        if (held != 0) begin
            view.front_value = slot_value[head_slot];
            view.back_value = slot_value[tail_slot - 4'd1];
            view.max_value = slot_suffix_max[head_slot];
        end
        view.count = held;
        view.is_empty = (held == 0);
        return view;
    endfunction

    initial begin
        fail_count = 0;
        pending_results = 0;
    end

    always @(posedge aclk) begin
        queue_view_t want;
        queue_view_t got;
        if (!aresetn) begin
            head_slot = '0;
            tail_slot = '0;
            held = '0;
            expected_views.delete();
        end else begin
            // An accepted operation is predicted first, so the order holds
            // even if its result came out within the same cycle.
            if (s_valid && s_ready)
                expected_views.push_back(apply_queue_op(s_cmd, s_value));

            if (m_valid && m_ready) begin
                got = '{m_front_value, m_back_value, m_max_value, m_count,
                        m_is_empty, m_status};
                if (expected_views.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (reported < MAX_REPORTS)
                        $display("%0t: result with nothing pending: %p", $realtime, got);
                    reported++;
                end else begin
                    want = expected_views.pop_front();
                    if (got.front_value !== want.front_value ||
                        got.back_value !== want.back_value ||
                        got.max_value !== want.max_value ||
                        got.count !== want.count ||
                        got.is_empty !== want.is_empty ||
                        got.status !== want.status) begin
                        fail_count <= fail_count + 1;
                        if (reported < MAX_REPORTS)
                            $display("%0t: result mismatch\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                        reported++;
                    end
                end
            end
        end
        pending_results <= expected_views.size();
    end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the max tracking queue with a short directed sequence and then with
// random operation mixes that swing the queue between empty and full, under
// several patterns of sender idling and receiver stalls. A checker instance
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import mtf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 320;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [15:0] s_value;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_front_value;
    logic [15:0] m_back_value;
    logic [15:0] m_max_value;
    logic [4:0]  m_count;
    logic        m_is_empty;
    logic [1:0]  m_status;

    int fail_count;
    int pending_results;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_ticket = 0;
    int hold_served = 0;
    int hold_left = 0;

    max_tracking_fifo #(
        .DEPTH      (16),
        .DATA_WIDTH (16)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_front_value (m_front_value),
        .m_back_value  (m_back_value),
        .m_max_value   (m_max_value),
        .m_count       (m_count),
        .m_is_empty    (m_is_empty),
        .m_status      (m_status)
    );

    max_queue_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_front_value   (m_front_value),
        .m_back_value    (m_back_value),
        .m_max_value     (m_max_value),
        .m_count         (m_count),
        .m_is_empty      (m_is_empty),
        .m_status        (m_status),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off whenever the stimulus
    // asks for one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_ticket != hold_served) begin
            hold_served <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item, after a random number of idle cycles, and wait until
    // it is taken.
    task automatic offer_op(input logic [1:0] op, input logic [15:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= op;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering until every predicted result has come back.
    task automatic drain_results();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
            guard++;
        end while (pending_results != 0 && guard < DRAIN_LIMIT);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    // Reads use both the named code and the unused one.
    function automatic logic [1:0] pick_op(input int push_pct, input int pop_pct);
        int r;
        r = $urandom_range(99);
        if (r < push_pct)
            return CMD_PUSH;
        if (r < push_pct + pop_pct)
            return CMD_POP;
        return ($urandom_range(1) == 0) ? CMD_READ : 2'd3;
    endfunction

    // Random operations in runs of 40, each run biased toward filling,
    // emptying or hovering, so both the full and the empty queue come up.
    task automatic run_random_ops(input int n);
        int push_pct;
        int pop_pct;
        push_pct = 45;
        pop_pct = 45;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) begin
                case ($urandom_range(2))
                    0: begin push_pct = 65; pop_pct = 25; end
                    1: begin push_pct = 25; pop_pct = 65; end
                    default: begin push_pct = 45; pop_pct = 45; end
                endcase
            end
            offer_op(pick_op(push_pct, pop_pct), pick_value());
        end
    endtask

    initial begin
        int guard;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_cmd <= CMD_READ;
        s_value <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty-queue flags, extreme values, the unused code
        // and suffix maxima that must fall as the front moves on.
        offer_op(CMD_READ, 16'h1234);
        offer_op(2'd3, 16'hFFFF);
        offer_op(CMD_POP, 16'h0000);
        offer_op(CMD_PUSH, 16'h0000);
        offer_op(CMD_PUSH, 16'hFFFF);
        offer_op(CMD_PUSH, 16'h0001);
        offer_op(CMD_READ, 16'h0000);
        offer_op(2'd3, 16'h5555);
        offer_op(CMD_POP, 16'hAAAA);
        offer_op(CMD_POP, 16'h0000);
        offer_op(CMD_POP, 16'h0000);
        offer_op(CMD_PUSH, 16'h0009);
        offer_op(CMD_PUSH, 16'h0003);
        offer_op(CMD_PUSH, 16'h0007);
        offer_op(CMD_PUSH, 16'h0002);
        offer_op(CMD_POP, 16'h0000);
        offer_op(CMD_POP, 16'h0000);
        offer_op(CMD_POP, 16'h0000);
        drain_results();

        // No idling, with one long receiver hold-off while pushes keep
        // coming, which fills the output path and then the queue itself.
        run_random_ops(ITEMS_PER_PHASE / 2);
        hold_ticket <= hold_ticket + 1;
        for (int i = 0; i < 24; i++)
            offer_op(CMD_PUSH, pick_value());
        drain_results();
        run_random_ops(ITEMS_PER_PHASE / 2);
        drain_results();

        // Mostly idle sender.
        send_idle_pct <= 87;
        recv_stall_pct <= 0;
        run_random_ops(ITEMS_PER_PHASE);
        drain_results();

        // Mostly stalled receiver.
        send_idle_pct <= 0;
        recv_stall_pct <= 87;
        run_random_ops(ITEMS_PER_PHASE);
        drain_results();

        // Light idling on both sides.
        send_idle_pct <= 15;
        recv_stall_pct <= 15;
        run_random_ops(ITEMS_PER_PHASE);
        s_valid <= 1'b0;

        // Wait for the last results, then keep watching for stray ones.
        guard = 0;
        do begin
            @(posedge aclk);
            guard++;
        end while (pending_results != 0 && guard < DRAIN_LIMIT);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending_results == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### max_tracking_fifo.f
+incdir+rtl/core
rtl/core/mtf_pkg.sv
rtl/core/mtf_cell.sv
rtl/core/max_tracking_fifo.sv
sim/max_queue_checker.sv
sim/tb.sv
